// ----- design/psxs_pkg.sv -----
// ----------------------------------------------------------------------------
// psxs_pkg: shared types and functions of the position seeded XOR scrambler
// Holds the word formats of both channels, the generator state type, the
// seeding keys and the generator step function.
// ----------------------------------------------------------------------------
package psxs_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [WordW-1:0] SeedAKey = 32'hcafebabe;
  localparam logic [WordW-1:0] SeedBKey = 32'hbada5511;
  localparam logic [WordW-1:0] SeedCKey = 32'd66;
  localparam logic [WordW-1:0] SeedBOfs = 32'd2;
  localparam logic [WordW-1:0] SeedCOfs = 32'd3;

  // Step count right after the seed and its mixing step.
  localparam logic [WordW-1:0] SeedCount = 32'd1;

  typedef struct packed {
    logic             frame_start;
    logic [WordW-1:0] frame_position;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_last;
  } out_word_t;

  typedef struct packed {
    logic [WordW-1:0] gen_a;
    logic [WordW-1:0] gen_b;
    logic [WordW-1:0] gen_c;
    logic [WordW-1:0] step_count;
  } gen_t;

  // One generator step; all sums wrap modulo 2^32.
  function automatic gen_t gen_step(gen_t s);
    gen_t r;
    r.step_count = s.step_count + 32'd1;
    r.gen_a      = s.gen_a ^ s.gen_c ^ r.step_count;
    r.gen_b      = s.gen_b + r.gen_a;
    r.gen_c      = (s.gen_c + (r.gen_b >> 1)) ^ r.gen_a;
    return r;
  endfunction

  // Generator state seeded from a frame position, before its mixing step.
  function automatic gen_t gen_seed(logic [WordW-1:0] pos);
    gen_t r;
    r.gen_a      = pos ^ SeedAKey;
    r.gen_b      = (pos - SeedBOfs) ^ SeedBKey;
    r.gen_c      = (pos - SeedCOfs) ^ SeedCKey;
    r.step_count = '0;
    return r;
  endfunction

endpackage

// ----- design/psxs_if.sv -----
// ----------------------------------------------------------------------------
// psxs_if: valid/ready channels of the position seeded XOR scrambler
// One interface for the input words and one for the result words.
// ----------------------------------------------------------------------------
interface psxs_in_if;
  logic               valid;
  logic               ready;
  psxs_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psxs_out_if;
  logic                valid;
  logic                ready;
  psxs_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/position_seeded_xor_scrambler.sv -----
// ----------------------------------------------------------------------------
// position_seeded_xor_scrambler: byte scrambler with a position seeded
// keystream
// Xors each byte with the low byte of a small add/xor/shift generator that
// is reseeded from the frame position on the first byte of each frame.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output is not stalled and
// returns one result word per input word, in order, through stage 1,
// stage 2 and the output register. The sustained rate is one word per clock
// when the output is not stalled, set by the generator state loop, which
// performs exactly one generator step per word. A word marked as frame start
// is seeded from its frame position in a stage ahead of that loop, so the
// loop never runs more than one step. Scrambling and descrambling are the
// same operation. The last flag passes through unchanged and never affects the keystream.
module position_seeded_xor_scrambler (
  input  logic             clk_i,
  input  logic             rst_ni,
  psxs_in_if.sink          in_i,
  psxs_out_if.source       out_o
);

  // Pipeline: stage 1 registers the input word; stage 2 holds the seeded
  // and once-stepped generator state for frame starts; the output stage
  // holds the result word while the live generator state advances.

  logic                           valid1_q;
  logic                           start1_q;
  logic [psxs_pkg::WordW-1:0]     pos1_q;
  logic [psxs_pkg::ByteW-1:0]     byte1_q;
  logic                           last1_q;

  logic                           valid2_q;
  logic                           start2_q;
  logic [psxs_pkg::ByteW-1:0]     byte2_q;
  logic                           last2_q;
  psxs_pkg::gen_t                 seeded2_q, seeded2_d;

  psxs_pkg::gen_t                 gen_q, gen_d, gen_base;

  logic                           out_valid_q;
  logic [psxs_pkg::ByteW-1:0]     out_byte_q;
  logic                           out_last_q;

  logic out_adv, s2_adv, s1_adv, in_fire, fire2;

  // A stage may move on when it is empty or the stage after it moves on.
  assign out_adv  = !out_valid_q || out_o.ready;
  assign s2_adv   = !valid2_q || out_adv;
  assign s1_adv   = !valid1_q || s2_adv;
  assign in_i.ready = s1_adv;
  assign in_fire  = in_i.valid && s1_adv;
  assign fire2    = valid2_q && out_adv;

  // Seeding is independent of the live state, so it is done ahead of time.
  assign seeded2_d = psxs_pkg::gen_step(psxs_pkg::gen_seed(pos1_q));

  // The only loop: choose the start point, then take one step.
  assign gen_base = start2_q ? seeded2_q : gen_q;
  assign gen_d    = psxs_pkg::gen_step(gen_base);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q    <= 1'b0;
      valid2_q    <= 1'b0;
      out_valid_q <= 1'b0;
      gen_q       <= '0;
    end else begin
      if (s1_adv) begin
        valid1_q <= in_i.valid;
      end
      if (s2_adv) begin
        valid2_q <= valid1_q;
      end
      if (out_adv) begin
        out_valid_q <= valid2_q;
      end
      if (fire2) begin
        gen_q <= gen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start1_q <= in_i.data.frame_start;
      pos1_q   <= in_i.data.frame_position;
      byte1_q  <= in_i.data.data_byte;
      last1_q  <= in_i.data.last_byte;
    end
    if (valid1_q && s2_adv) begin
      start2_q  <= start1_q;
      byte2_q   <= byte1_q;
      last2_q   <= last1_q;
      seeded2_q <= seeded2_d;
    end
    if (fire2) begin
      out_byte_q <= byte2_q ^ gen_d.gen_c[psxs_pkg::ByteW-1:0];
      out_last_q <= last2_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.data.out_byte = out_byte_q;
  assign out_o.data.out_last = out_last_q;

  // A word that continues a frame advances the step count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire2 && !start2_q |=> gen_q.step_count == $past(gen_q.step_count) + 32'd1)
    else $error("step count did not advance by one");

  // A frame start leaves the generator two steps past its seed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire2 && start2_q |=> gen_q.step_count == psxs_pkg::SeedCount + 32'd1)
    else $error("frame start did not restart the step count");

  // The generator state moves only when a word enters the output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire2 |=> $stable(gen_q))
    else $error("generator state changed without a word");

  // A stalled stage 1 word is neither lost nor overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid1_q && !s2_adv |=> valid1_q && $stable(byte1_q) && $stable(last1_q))
    else $error("stage 1 word lost under stall");

  // The last flag of a result follows the word that produced it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire2 |=> out_valid_q && out_last_q == $past(last2_q))
    else $error("last flag not carried to the output");

endmodule

// ----- tb/psxs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psxs_checker: result checker of the position seeded XOR scrambler
// Watches both channels, keeps its own keystream generator in step with
// every accepted input word and compares each result word in order.
// ----------------------------------------------------------------------------
module psxs_checker (
  input  logic clk_i,
  input  logic rst_ni,
  psxs_in_if   in_mon_i,
  psxs_out_if  out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [psxs_pkg::WordW-1:0] PosKeyA = 32'hcafebabe;
  localparam logic [psxs_pkg::WordW-1:0] PosKeyB = 32'hbada5511;
  localparam logic [psxs_pkg::WordW-1:0] PosKeyC = 32'd66;
  localparam int                         MaxShown = 10;

  typedef struct packed {
    logic [psxs_pkg::WordW-1:0] a;
    logic [psxs_pkg::WordW-1:0] b;
    logic [psxs_pkg::WordW-1:0] c;
    logic [psxs_pkg::WordW-1:0] steps;
  } keystream_t;

  keystream_t          keystream;
  psxs_pkg::out_word_t scrambled_q[$];
  int                  errors = 0;
  int                  outstanding = 0;

  assign fail_count_o = errors;
  assign pending_o    = outstanding;

  function automatic keystream_t keystream_advance(keystream_t k);
    keystream_t n;
    n.steps = k.steps + 32'd1;
    n.a     = k.a ^ k.c ^ n.steps;
    n.b     = k.b + n.a;
    n.c     = (k.c + (n.b >> 1)) ^ n.a;
    return n;
  endfunction

  // Seed from the frame position, including the mixing step.
  function automatic keystream_t keystream_reseed(logic [psxs_pkg::WordW-1:0] pos);
    keystream_t k;
    k.a     = pos ^ PosKeyA;
    k.b     = (pos - 32'd2) ^ PosKeyB;
    k.c     = (pos - 32'd3) ^ PosKeyC;
    k.steps = '0;
    return keystream_advance(k);
  endfunction

  task automatic flag(input string msg);
    errors++;
    if (errors <= MaxShown) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    keystream_t          next;
    psxs_pkg::in_word_t  w;
    psxs_pkg::out_word_t got;
    psxs_pkg::out_word_t want;
    if (!rst_ni) begin
      keystream = '0;
      scrambled_q.delete();
    end else begin
      // Results first, so a result word that comes out on the same edge as its
      // input word is never matched against the expectation pushed on that edge.
      if (out_mon_i.valid === 1'b1 && out_mon_i.ready === 1'b1) begin
        got = out_mon_i.data;
        if (scrambled_q.size() == 0) begin
          flag($sformatf("unexpected result word byte=%02h last=%b",
                         got.out_byte, got.out_last));
        end else begin
          want = scrambled_q.pop_front();
          if (got.out_byte !== want.out_byte)
            flag($sformatf("out_byte expected %02h got %02h",
                           want.out_byte, got.out_byte));
          if (got.out_last !== want.out_last)
            flag($sformatf("out_last expected %b got %b",
                           want.out_last, got.out_last));
        end
      end
      if (in_mon_i.valid === 1'b1 && in_mon_i.ready === 1'b1) begin
        w    = in_mon_i.data;
        next = w.frame_start ? keystream_reseed(w.frame_position) : keystream;
        next = keystream_advance(next);
        keystream = next;
        scrambled_q.push_back('{out_byte: w.data_byte ^ next.c[psxs_pkg::ByteW-1:0],
                                out_last: w.last_byte});
      end
    end
    outstanding = scrambled_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression of the position seeded XOR scrambler
// Sends a directed set of words followed by random frames and noise, with
// random gaps on the input side and random stalls on the result side. The
// checker beside the block predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  MaxIdle     = 18;
  localparam int  RandomWords = 750;
  // Slowest run: about 780 words, each waiting out the longest input gap
  // and the longest result stall plus the pipeline. The limit is several
  // times that.
  localparam int  CycleLimit  = 200000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   words_sent = 0;

  // Calm stretches: while set, the side in question never idles.
  bit   send_calm = 1'b0;
  bit   recv_calm = 1'b0;

  psxs_in_if  in_ch ();
  psxs_out_if out_ch ();

  position_seeded_xor_scrambler DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  psxs_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("position_seeded_xor_scrambler regression: fail");
      $finish;
    end
  end

  function automatic int idle_cycles(input bit calm);
    return calm ? 0 : $urandom_range(0, MaxIdle);
  endfunction

  function automatic psxs_pkg::in_word_t make_word(input logic start,
                                                   input logic [psxs_pkg::WordW-1:0] pos,
                                                   input logic [psxs_pkg::ByteW-1:0] data,
                                                   input logic last);
    psxs_pkg::in_word_t w;
    w.frame_start    = start;
    w.frame_position = pos;
    w.data_byte      = data;
    w.last_byte      = last;
    return w;
  endfunction

  // Called and returning at a falling edge. Valid stays high into the next
  // word when no gap is drawn, so it is assigned only once per step.
  task automatic send_word(input psxs_pkg::in_word_t w);
    int gap;
    gap = idle_cycles(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Holds the input side back until every result word has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Frame positions favor values near zero, where pos-2 and pos-3 wrap, and values near the top of the range.
  function automatic logic [psxs_pkg::WordW-1:0] pick_position();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 4);
      1:       return 32'hffffffff - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // A frame with random content, opened by a frame start; sometimes the
  // last flag is dropped, which does not affect the keystream.
  task automatic send_frame();
    int len;
    bit truncated;
    len       = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    truncated = ($urandom_range(0, 11) == 0);
    for (int i = 0; i < len; i++) begin
      send_word(make_word(i == 0, (i == 0) ? pick_position() : $urandom,
                          8'($urandom_range(0, 255)), (i == len - 1) && !truncated));
    end
  endtask

  // Result side: one stall draw per result word, ready held until it moves.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      stall = idle_cycles(recv_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni      = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Words before any frame start run the generator from its all-zero
    // reset state; the position is ignored without a frame start, and a
    // last flag does not stop the keystream.
    send_word(make_word(1'b0, 32'h00000000, 8'h00, 1'b0));
    send_word(make_word(1'b0, 32'hffffffff, 8'hff, 1'b0));
    send_word(make_word(1'b0, 32'h5a5a5a5a, 8'h3c, 1'b1));
    send_word(make_word(1'b0, 32'h00000000, 8'ha5, 1'b0));
    // Position zero and one: the seed offsets wrap around.
    send_word(make_word(1'b1, 32'h00000000, 8'h00, 1'b0));
    send_word(make_word(1'b0, 32'h00000000, 8'hff, 1'b1));
    send_word(make_word(1'b1, 32'h00000001, 8'h12, 1'b0));
    // One-byte frames: seed, mixing step and the byte's own step at once.
    send_word(make_word(1'b1, 32'h00000002, 8'h80, 1'b1));
    send_word(make_word(1'b1, 32'h00000003, 8'h01, 1'b1));
    send_word(make_word(1'b1, 32'hffffffff, 8'hff, 1'b0));
    send_word(make_word(1'b0, 32'h00000000, 8'h80, 1'b0));
    send_word(make_word(1'b0, 32'hffffffff, 8'h01, 1'b1));
    // Continuation after a last word without a new frame start.
    send_word(make_word(1'b0, 32'h12345678, 8'h7e, 1'b0));
    send_word(make_word(1'b1, 32'h80000000, 8'h7f, 1'b1));
    // Positions that zero one of the seeded words.
    send_word(make_word(1'b1, 32'hcafebabe, 8'h55, 1'b0));
    // Restart in the middle of a frame.
    send_word(make_word(1'b1, 32'h7fffffff, 8'haa, 1'b0));
    send_word(make_word(1'b1, 32'hbada5513, 8'hc3, 1'b1));
    send_word(make_word(1'b1, 32'h00000045, 8'h0f, 1'b1));
    send_word(make_word(1'b0, 32'h00000000, 8'hf0, 1'b0));
    drain_results();

    // The step counter wrap needs 2^32 words and is out of reach here.
    // Random part: mostly frames, the rest single words with random flags.
    words_sent = 0;
    while (words_sent < RandomWords) begin
      if ($urandom_range(0, 7) == 0) send_calm = !send_calm;
      if ($urandom_range(0, 5) == 0) begin
        send_word(make_word(1'($urandom_range(0, 1)), $urandom,
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end else begin
        send_frame();
      end
      if ($urandom_range(0, 39) == 0) drain_results();
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    // The pipeline is three stages deep; give any stray word time to show.
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("position_seeded_xor_scrambler regression: pass");
    end else begin
      $display("position_seeded_xor_scrambler regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/psxs_pkg.sv
design/psxs_if.sv
design/position_seeded_xor_scrambler.sv
tb/psxs_checker.sv
tb/testbench.sv
